### sv/pid_aw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_aw_pkg
// Shared widths, sequencer states, register indexes and fixed-point helpers
// for the PID controller with integral clamp.
// ----------------------------------------------------------------------------
package pid_aw_pkg;

    // fixed-point format and datapath widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int LIM_W      = 31;
    localparam int OP_W       = DATA_W + 1;          // signed multiplier operand
    localparam int PROD_W     = 2 * OP_W;            // full product
    localparam int SUM_W      = DATA_W + 2;          // three-term sum, no overflow
    localparam int DIFF_W     = DATA_W + 1;          // error difference
    localparam int NUM_W      = DIFF_W + FRAC_BITS;  // scaled dividend
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int CFG_ADDR_W = 3;

    typedef logic signed [DATA_W-1:0] t_word;

    // word commands
    typedef enum logic {
        CMD_COMPUTE = 1'b0,
        CMD_CLEAR   = 1'b1
    } t_cmd;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_INT,
        ST_ACC_INT,
        ST_DIV,
        ST_DIV_END,
        ST_MUL_P,
        ST_ACC_P,
        ST_MUL_I,
        ST_ACC_I,
        ST_MUL_D,
        ST_ACC_D,
        ST_FINISH
    } t_state;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_P  = 3'd0,
        CFG_GAIN_I  = 3'd1,
        CFG_GAIN_D  = 3'd2,
        CFG_INT_LIM = 3'd3,
        CFG_OUT_LIM = 3'd4
    } t_cfg_idx;

    // saturation bounds at product width
    localparam logic signed [PROD_W-1:0] PROD_MAX =
        {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] PROD_MIN =
        {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // rescale a product by FRAC_BITS (floor) and saturate to one word
    function automatic t_word qscale(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] shifted;
        shifted = prod >>> FRAC_BITS;
        if (shifted > PROD_MAX) begin
            qscale = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (shifted < PROD_MIN) begin
            qscale = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            qscale = shifted[DATA_W-1:0];
        end
    endfunction

    // symmetric clamp to +/- lim; result always fits one word
    function automatic t_word clamp_sym(input logic signed [SUM_W-1:0] x,
                                        input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] pos;
        logic signed [SUM_W-1:0] neg;
        pos = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        neg = -pos;
        if (x > pos) begin
            clamp_sym = pos[DATA_W-1:0];
        end else if (x < neg) begin
            clamp_sym = neg[DATA_W-1:0];
        end else begin
            clamp_sym = x[DATA_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

### sv/pid_controller_antiwindup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Fixed-point PID step with clamped integral and saturated drive, built
// around one shared 33x33 multiplier and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_command, i_error_in, i_time_step
//  result    out        o_valid / i_ready    o_drive, o_skipped
//  config    in         i_cfg_wen            i_cfg_addr, i_cfg_wdata
//
//  A normal compute runs the integral multiply and accumulate, NUM_W (49)
//  restoring divider steps and a sign and saturate step for the derivative,
//  a multiply and accumulate for each of the three gain products, and a
//  final clamp and load. The first compute after reset or a clear skips
//  the divider. A clear or a zero time step jumps from idle to finish.
//  o_ready is high only in idle; a stalled result sits in the output
//  register while the next word may already be accepted, and that word's
//  result then waits in the finish state until the register is free.
//  Reset is synchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration
    input  wire                                i_cfg_wen,
    input  wire [pid_aw_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire [pid_aw_pkg::DATA_W-1:0]       i_cfg_wdata,
    // input words
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire                                i_command,
    input  wire signed [pid_aw_pkg::DATA_W-1:0] i_error_in,
    input  wire [pid_aw_pkg::DATA_W-1:0]       i_time_step,
    // result words
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic signed [pid_aw_pkg::DATA_W-1:0] o_drive,
    output logic                               o_skipped
);
    import pid_aw_pkg::*;

    // sequencer and control state
    t_state                   r_state, n_state;
    logic                     r_out_valid, n_out_valid;
    t_word                    r_gain_p, n_gain_p;
    t_word                    r_gain_i, n_gain_i;
    t_word                    r_gain_d, n_gain_d;
    logic [LIM_W-1:0]         r_int_lim, n_int_lim;
    logic [LIM_W-1:0]         r_out_lim, n_out_lim;
    t_word                    r_integral, n_integral;
    t_word                    r_last_err, n_last_err;
    logic                     r_first_step, n_first_step;

    // working registers
    t_word                    r_err, n_err;
    logic [DATA_W-1:0]        r_dt, n_dt;
    logic signed [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0]        r_rem, n_rem;
    logic [NUM_W-1:0]         r_quo, n_quo;
    logic                     r_neg, n_neg;
    logic [DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic                     r_use_deriv, n_use_deriv;
    t_word                    r_deriv, n_deriv;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic                     r_res_skip, n_res_skip;
    t_word                    r_drive, n_drive;
    logic                     r_skipped, n_skipped;

    // shared datapath nets
    logic signed [OP_W-1:0]   w_op_a, w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    t_word                    w_term;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_mag;
    logic [DATA_W:0]          w_trial;
    logic [DATA_W:0]          w_sub;
    logic                     w_ge;
    logic signed [SUM_W-1:0]  w_int_sum;

    // multiplier operand select, one product per cycle
    always_comb begin
        case (r_state)
            ST_MUL_INT: begin
                w_op_a = {r_err[DATA_W-1], r_err};
                w_op_b = $signed({1'b0, r_dt});
            end
            ST_MUL_P: begin
                w_op_a = {r_gain_p[DATA_W-1], r_gain_p};
                w_op_b = {r_err[DATA_W-1], r_err};
            end
            ST_MUL_I: begin
                w_op_a = {r_gain_i[DATA_W-1], r_gain_i};
                w_op_b = {r_integral[DATA_W-1], r_integral};
            end
            ST_MUL_D: begin
                w_op_a = {r_gain_d[DATA_W-1], r_gain_d};
                w_op_b = {r_deriv[DATA_W-1], r_deriv};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;
    assign w_term = qscale(r_prod);

    // error difference and its magnitude for the divider
    assign w_diff = $signed({i_error_in[DATA_W-1], i_error_in})
                  - $signed({r_last_err[DATA_W-1], r_last_err});
    assign w_mag  = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);

    // one restoring divide step
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dt});
    assign w_sub   = w_trial - {1'b0, r_dt};

    assign w_int_sum = SUM_W'(r_integral) + SUM_W'(w_term);

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_gain_p     = r_gain_p;
        n_gain_i     = r_gain_i;
        n_gain_d     = r_gain_d;
        n_int_lim    = r_int_lim;
        n_out_lim    = r_out_lim;
        n_integral   = r_integral;
        n_last_err   = r_last_err;
        n_first_step = r_first_step;
        n_err        = r_err;
        n_dt         = r_dt;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_neg        = r_neg;
        n_cnt        = r_cnt;
        n_use_deriv  = r_use_deriv;
        n_deriv      = r_deriv;
        n_sum        = r_sum;
        n_res_skip   = r_res_skip;
        n_drive      = r_drive;
        n_skipped    = r_skipped;

        // register writes
        if (i_cfg_wen) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_GAIN_P:  n_gain_p  = i_cfg_wdata;
                CFG_GAIN_I:  n_gain_i  = i_cfg_wdata;
                CFG_GAIN_D:  n_gain_d  = i_cfg_wdata;
                CFG_INT_LIM: n_int_lim = i_cfg_wdata[LIM_W-1:0];
                CFG_OUT_LIM: n_out_lim = i_cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end

        // result taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_sum = '0;
                    if (i_command == CMD_CLEAR) begin
                        // clear: reset integral, restart derivative
                        n_integral   = '0;
                        n_last_err   = '0;
                        n_first_step = 1'b1;
                        n_res_skip   = 1'b1;
                        n_state      = ST_FINISH;
                    end else if (i_time_step == '0) begin
                        n_res_skip = 1'b1;
                        n_state    = ST_FINISH;
                    end else begin
                        n_err        = i_error_in;
                        n_dt         = i_time_step;
                        n_neg        = w_diff[DIFF_W-1];
                        n_quo        = {w_mag, {FRAC_BITS{1'b0}}};
                        n_rem        = '0;
                        n_cnt        = '0;
                        n_use_deriv  = !r_first_step;
                        n_first_step = 1'b0;
                        n_last_err   = i_error_in;
                        n_res_skip   = 1'b0;
                        n_state      = ST_MUL_INT;
                    end
                end
            end
            ST_MUL_INT: n_state = ST_ACC_INT;
            ST_ACC_INT: begin
                n_integral = clamp_sym(w_int_sum, r_int_lim);
                if (r_use_deriv) begin
                    n_state = ST_DIV;
                end else begin
                    n_deriv = '0;
                    n_state = ST_MUL_P;
                end
            end
            ST_DIV: begin
                n_rem = w_ge ? w_sub[DATA_W-1:0] : w_trial[DATA_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    n_state = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                // apply sign, saturate quotient to one word
                if (!r_neg) begin
                    if (|r_quo[NUM_W-1:DATA_W-1]) begin
                        n_deriv = {1'b0, {(DATA_W-1){1'b1}}};
                    end else begin
                        n_deriv = r_quo[DATA_W-1:0];
                    end
                end else begin
                    if ((|r_quo[NUM_W-1:DATA_W])
                        || (r_quo[DATA_W-1] && (|r_quo[DATA_W-2:0]))) begin
                        n_deriv = {1'b1, {(DATA_W-1){1'b0}}};
                    end else begin
                        n_deriv = -r_quo[DATA_W-1:0];
                    end
                end
                n_state = ST_MUL_P;
            end
            ST_MUL_P: n_state = ST_ACC_P;
            ST_ACC_P: begin
                n_sum   = r_sum + SUM_W'(w_term);
                n_state = ST_MUL_I;
            end
            ST_MUL_I: n_state = ST_ACC_I;
            ST_ACC_I: begin
                n_sum   = r_sum + SUM_W'(w_term);
                n_state = ST_MUL_D;
            end
            ST_MUL_D: n_state = ST_ACC_D;
            ST_ACC_D: begin
                n_sum   = r_sum + SUM_W'(w_term);
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                // load output register once it is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_drive     = clamp_sym(r_sum, r_out_lim);
                    n_skipped   = r_res_skip;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_int_lim    <= '1;
            r_out_lim    <= '1;
            r_integral   <= '0;
            r_last_err   <= '0;
            r_first_step <= 1'b1;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_gain_p     <= n_gain_p;
            r_gain_i     <= n_gain_i;
            r_gain_d     <= n_gain_d;
            r_int_lim    <= n_int_lim;
            r_out_lim    <= n_out_lim;
            r_integral   <= n_integral;
            r_last_err   <= n_last_err;
            r_first_step <= n_first_step;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_err       <= n_err;
        r_dt        <= n_dt;
        r_prod      <= w_prod;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_neg       <= n_neg;
        r_cnt       <= n_cnt;
        r_use_deriv <= n_use_deriv;
        r_deriv     <= n_deriv;
        r_sum       <= n_sum;
        r_res_skip  <= n_res_skip;
        r_drive     <= n_drive;
        r_skipped   <= n_skipped;
    end

    assign o_ready   = (r_state == ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_drive   = r_drive;
    assign o_skipped = r_skipped;

endmodule
`default_nettype wire

### sv/pid_aw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_aw_checker
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pid_aw_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wen,
    input  wire [pid_aw_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire [pid_aw_pkg::DATA_W-1:0]       i_cfg_wdata,
    input  wire                                i_valid,
    input  wire                                o_ready,
    input  wire                                o_valid,
    input  wire                                i_ready,
    input  wire [pid_aw_pkg::DATA_W-1:0]       o_drive,
    input  wire                                o_skipped
);
    import pid_aw_pkg::*;

    // shadow of the drive limit as seen on the config port
    logic [LIM_W-1:0] r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= '1;
        end else if (i_cfg_wen && (i_cfg_addr == CFG_OUT_LIM)) begin
            r_lim <= i_cfg_wdata[LIM_W-1:0];
        end
    end

    // skipped words always carry a zero drive
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_skipped |-> (o_drive == '0))
        else $error("skipped word with nonzero drive");

    // drive stays inside the programmed limit
    a_drive_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_skipped |->
            ($signed(o_drive) <= $signed({1'b0, r_lim}))
            && ($signed(o_drive) >= -$signed({1'b0, r_lim})))
        else $error("drive outside output limit");

    // one word in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted a second word while busy");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_drive) && $stable(o_skipped))
        else $error("stalled result changed");

    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("not idle after reset");

endmodule

bind pid_controller_antiwindup pid_aw_checker u_pid_aw_checker (.*);
`default_nettype wire
